// ----- rtl/core/bqlp_pkg.sv -----
// Shared constants and types of the biquad low-pass filter with output gain.
`default_nettype none

package bqlp_pkg;

  // Default width of the audio sample carried in the low bits of each input word.
  localparam int unsigned SAMPLE_BITS_DEF = 24;
  // Fraction bits of the filter coefficients (Q3.28).
  localparam int unsigned COEF_FRAC_BITS  = 28;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned Q_W        = 48;  // feedback outputs, Q32.16
  localparam int unsigned Q_HALF_W   = 24;  // feedback outputs enter the multiplier in halves
  localparam int unsigned Q_FRAC_W   = 16;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_HDR_W  = WORD_W - OUT_DATA_W;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [OUT_HDR_W-1:0] OUT_HEADER = 8'hFF;
  localparam logic [GAIN_W-1:0]    GAIN_RESET = 17'h10000;

  // Register index, taken from paddr[4:2].
  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } reg_idx_e;

  // Left shift applied to a product before it enters the accumulator.
  typedef enum logic [1:0] {
    SHL_0  = 2'd0,
    SHL_16 = 2'd1,
    SHL_24 = 2'd2
  } shl_e;

endpackage

`default_nettype wire

// ----- rtl/core/biquad_lowpass_with_gain.sv -----
// Direct-form-I biquad low-pass filter with output gain, built on one shared multiplier.
`default_nettype none

// Usage
// The input channel (in_valid_i, in_ready_o, in_word_i) takes one audio sample per beat
// in the low SAMPLE_BITS bits of the word, read as two's complement. The output channel
// (out_valid_o, out_ready_i, out_word_o) returns one beat per input beat, with 0xFF in
// bits 31..24 and the filtered, gain-scaled sample, wrapped to 24 bits, below.
// Coefficients and gain are written through the APB port (b0, b1, b2, a1, a2 at byte
// addresses 0x00..0x10, gain at 0x14); reads return them. The user must write them only
// while no sample is in flight; the block itself does not enforce this.
// From accept to output valid, the single 32 x 25 bit multiplier first computes the
// seven partial products of the filter sum (the 48-bit feedback outputs enter it in
// two halves); then the sum is shifted and saturated, cut to an integer and multiplied
// by the gain, and the product is loaded into the output register. The block is ready
// again once that register is loaded and takes no new sample while one is in process.
// The output register holds a finished beat, so the next sample is taken and processed
// while that beat waits. If the receiver still stalls when the next result is ready,
// the block holds that result in its last step and takes no input until it drains.
// Reset clears the filter history and the coefficients and sets the gain to unity.
module biquad_lowpass_with_gain #(
  parameter int unsigned SAMPLE_BITS = bqlp_pkg::SAMPLE_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // Sample input
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [bqlp_pkg::WORD_W-1:0]       in_word_i,
  // Result output
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [bqlp_pkg::WORD_W-1:0]       out_word_o,
  // Configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [bqlp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [bqlp_pkg::COEF_W-1:0]       pwdata,
  output logic [bqlp_pkg::COEF_W-1:0]       prdata,
  output logic                              pready
);
  import bqlp_pkg::*;

  // Multiplier B operand holds a sample, a feedback half or the gain.
  localparam int unsigned MB_W   = ((SAMPLE_BITS > Q_HALF_W) ? SAMPLE_BITS : Q_HALF_W) + 1;
  localparam int unsigned PROD_W = COEF_W + MB_W;
  // The accumulator holds the exact filter sum before scaling.
  localparam int unsigned FF_W   = COEF_W + SAMPLE_BITS + 2 + Q_FRAC_W;
  localparam int unsigned FB_W   = COEF_W + Q_W + 1;
  localparam int unsigned ACC_W  = ((FF_W > FB_W) ? FF_W : FB_W) + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SAT,
    ST_TRUNC,
    ST_GMUL,
    ST_OUT
  } state_e;

  // Configuration registers
  logic signed [COEF_W-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  logic [GAIN_W-1:0]        out_gain_q;
  reg_idx_e                 reg_idx;
  logic                     cfg_wr;

  // Datapath state
  state_e                    state_q;
  logic [2:0]                step_q;
  logic signed [SAMPLE_BITS-1:0] x_q, prev_in_1_q, prev_in_2_q;
  logic signed [Q_W-1:0]     prev_out_1_q, prev_out_2_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [PROD_W-1:0]  prod_q;
  shl_e                      prod_shl_q, mul_shl;
  logic                      prod_sub_q, mul_sub;
  logic signed [COEF_W-1:0]  whole_q, whole_d;
  logic                      out_valid_q;
  logic [WORD_W-1:0]         out_word_q;

  // Shared multiplier
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_shr;
  logic                      sat_ovf;
  logic signed [Q_W-1:0]     y_sat;
  logic signed [Q_W-1:0]     y_bias;
  logic signed [PROD_W-1:0]  p_bias;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q  <= '0;
      coef_b1_q  <= '0;
      coef_b2_q  <= '0;
      coef_a1_q  <= '0;
      coef_a2_q  <= '0;
      out_gain_q <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_B0:   coef_b0_q  <= pwdata;
        REG_B1:   coef_b1_q  <= pwdata;
        REG_B2:   coef_b2_q  <= pwdata;
        REG_A1:   coef_a1_q  <= pwdata;
        REG_A2:   coef_a2_q  <= pwdata;
        REG_GAIN: out_gain_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_B0:   prdata = coef_b0_q;
      REG_B1:   prdata = coef_b1_q;
      REG_B2:   prdata = coef_b2_q;
      REG_A1:   prdata = coef_a1_q;
      REG_A2:   prdata = coef_a2_q;
      REG_GAIN: prdata = {{(COEF_W-GAIN_W){1'b0}}, out_gain_q};
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Operand selection. Sum steps 0 to 6 each issue one partial product; the
  // feedback outputs are split into an unsigned low half and a signed high half.
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_shl = SHL_0;
    mul_sub = 1'b0;
    if (state_q == ST_GMUL) begin
      mul_a = whole_q;
      mul_b = {{(MB_W-GAIN_W){1'b0}}, out_gain_q};
    end else begin
      unique case (step_q)
        3'd0: begin
          mul_a   = coef_b0_q;
          mul_b   = {{(MB_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
          mul_shl = SHL_16;
        end
        3'd1: begin
          mul_a   = coef_b1_q;
          mul_b   = {{(MB_W-SAMPLE_BITS){prev_in_1_q[SAMPLE_BITS-1]}}, prev_in_1_q};
          mul_shl = SHL_16;
        end
        3'd2: begin
          mul_a   = coef_b2_q;
          mul_b   = {{(MB_W-SAMPLE_BITS){prev_in_2_q[SAMPLE_BITS-1]}}, prev_in_2_q};
          mul_shl = SHL_16;
        end
        3'd3: begin
          mul_a   = coef_a1_q;
          mul_b   = {{(MB_W-Q_HALF_W){1'b0}}, prev_out_1_q[Q_HALF_W-1:0]};
          mul_sub = 1'b1;
        end
        3'd4: begin
          mul_a   = coef_a1_q;
          mul_b   = {{(MB_W-Q_HALF_W){prev_out_1_q[Q_W-1]}}, prev_out_1_q[Q_W-1:Q_HALF_W]};
          mul_shl = SHL_24;
          mul_sub = 1'b1;
        end
        3'd5: begin
          mul_a   = coef_a2_q;
          mul_b   = {{(MB_W-Q_HALF_W){1'b0}}, prev_out_2_q[Q_HALF_W-1:0]};
          mul_sub = 1'b1;
        end
        3'd6: begin
          mul_a   = coef_a2_q;
          mul_b   = {{(MB_W-Q_HALF_W){prev_out_2_q[Q_W-1]}}, prev_out_2_q[Q_W-1:Q_HALF_W]};
          mul_shl = SHL_24;
          mul_sub = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Accumulate the product registered in the previous step.
  always_comb begin
    unique case (prod_shl_q)
      SHL_16:  term = ACC_W'(prod_q) <<< Q_FRAC_W;
      SHL_24:  term = ACC_W'(prod_q) <<< Q_HALF_W;
      default: term = ACC_W'(prod_q);
    endcase
    acc_d = prod_sub_q ? (acc_q - term) : (acc_q + term);
  end

  // Floor shift to Q32.16, then saturate to 48 bits.
  assign acc_shr = acc_q >>> COEF_FRAC_BITS;
  assign sat_ovf = (acc_shr[ACC_W-1:Q_W-1] != {(ACC_W-Q_W+1){acc_shr[ACC_W-1]}});
  always_comb begin
    if (!sat_ovf) begin
      y_sat = acc_shr[Q_W-1:0];
    end else if (acc_shr[ACC_W-1]) begin
      y_sat = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  // Truncation toward zero: add 2^16-1 to a negative value before the shift.
  assign y_bias  = prev_out_1_q + {{(Q_W-Q_FRAC_W){1'b0}}, {Q_FRAC_W{prev_out_1_q[Q_W-1]}}};
  assign whole_d = y_bias[Q_W-1:Q_FRAC_W];
  assign p_bias  = prod_q + {{(PROD_W-Q_FRAC_W){1'b0}}, {Q_FRAC_W{prod_q[PROD_W-1]}}};

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      x_q          <= '0;
      prev_in_1_q  <= '0;
      prev_in_2_q  <= '0;
      prev_out_1_q <= '0;
      prev_out_2_q <= '0;
      acc_q        <= '0;
      prod_q       <= '0;
      prod_shl_q   <= SHL_0;
      prod_sub_q   <= 1'b0;
      whole_q      <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
    end else begin
      // A finished result loads the output register once it is free or drains now.
      if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        out_word_q  <= {OUT_HEADER, p_bias[Q_FRAC_W+OUT_DATA_W-1:Q_FRAC_W]};
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            x_q     <= in_word_i[SAMPLE_BITS-1:0];
            acc_q   <= '0;
            step_q  <= '0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          prod_q     <= mul_p;
          prod_shl_q <= mul_shl;
          prod_sub_q <= mul_sub;
          if (step_q != 3'd0) begin
            acc_q <= acc_d;
          end
          step_q <= step_q + 3'd1;
          if (step_q == 3'd7) begin
            state_q <= ST_SAT;
          end
        end
        ST_SAT: begin
          prev_in_2_q  <= prev_in_1_q;
          prev_in_1_q  <= x_q;
          prev_out_2_q <= prev_out_1_q;
          prev_out_1_q <= y_sat;
          state_q      <= ST_TRUNC;
        end
        ST_TRUNC: begin
          whole_q <= whole_d;
          state_q <= ST_GMUL;
        end
        ST_GMUL: begin
          prod_q  <= mul_p;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_starts_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MAC && step_q == 3'd0))
    else $error("accepted sample did not start the multiply sequence");

  a_result_from_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result beat appeared outside the output step");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_o && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("pending result overwritten while receiver stalls");

  a_mac_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SAT) |-> $past(state_q == ST_MAC && step_q == 3'd7))
    else $error("saturation step entered before the sum completed");

endmodule

`default_nettype wire
